>>> rtl/pid_step_with_antiwindup_defines.svh
// Assertion helpers for the PID step block.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef PID_STEP_WITH_ANTIWINDUP_DEFINES_SVH
`define PID_STEP_WITH_ANTIWINDUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDAW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDAW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pidaw_pkg.sv
`timescale 1ns / 1ps
package pidaw_pkg;

	localparam int DATA_W  = 16;
	localparam int ACC_W   = 32;
	localparam int DIFF_W  = DATA_W + 1;
	localparam int PP_W    = 2 * DATA_W;
	localparam int PI_W    = DATA_W + ACC_W;
	localparam int PD_W    = DATA_W + DIFF_W;
	localparam int SUM_W   = PI_W + 2;
	localparam int FRAC_W  = 8;
	localparam int IDX_W   = 3;
	localparam int CLAMP_W = 2;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [IDX_W-1:0] REG_OUT_FLOOR   = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUT_CEILING = 3'd4;

	localparam logic signed [DATA_W-1:0] RST_GAIN_P      = 16'sd256;
	localparam logic signed [DATA_W-1:0] RST_GAIN_I      = 16'sd0;
	localparam logic signed [DATA_W-1:0] RST_GAIN_D      = 16'sd0;
	localparam logic signed [DATA_W-1:0] RST_OUT_FLOOR   = 16'sh8000;
	localparam logic signed [DATA_W-1:0] RST_OUT_CEILING = 16'sh7fff;

	typedef enum logic [CLAMP_W-1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_HIGH = 2'd1,
		CLAMP_LOW  = 2'd2
	} clamp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic signed [DATA_W-1:0] out_floor;
		logic signed [DATA_W-1:0] out_ceiling;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		clamp_t                   clamp;
		logic signed [ACC_W-1:0]  accum_next;
	} step_t;

endpackage

>>> rtl/pidaw_cfg.sv
`timescale 1ns / 1ps
module pidaw_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidaw_pkg::IDX_W-1:0]         cfg_index,
	input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata,
	output pidaw_pkg::cfg_t                     cfg
);

	pidaw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= pidaw_pkg::RST_GAIN_P;
			cfg_q.gain_i      <= pidaw_pkg::RST_GAIN_I;
			cfg_q.gain_d      <= pidaw_pkg::RST_GAIN_D;
			cfg_q.out_floor   <= pidaw_pkg::RST_OUT_FLOOR;
			cfg_q.out_ceiling <= pidaw_pkg::RST_OUT_CEILING;
		end else if (cfg_we) begin
			case (cfg_index)
				pidaw_pkg::REG_GAIN_P:      cfg_q.gain_p      <= cfg_wdata;
				pidaw_pkg::REG_GAIN_I:      cfg_q.gain_i      <= cfg_wdata;
				pidaw_pkg::REG_GAIN_D:      cfg_q.gain_d      <= cfg_wdata;
				pidaw_pkg::REG_OUT_FLOOR:   cfg_q.out_floor   <= cfg_wdata;
				pidaw_pkg::REG_OUT_CEILING: cfg_q.out_ceiling <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/pidaw_calc.sv
`timescale 1ns / 1ps
module pidaw_calc (
	input  pidaw_pkg::cfg_t                     cfg,
	input  logic signed [pidaw_pkg::DATA_W-1:0] err,
	input  logic signed [pidaw_pkg::ACC_W-1:0]  accum,
	input  logic signed [pidaw_pkg::DATA_W-1:0] last_err,
	output pidaw_pkg::step_t                    step
);

	localparam int DW = pidaw_pkg::DATA_W;
	localparam int AW = pidaw_pkg::ACC_W;
	localparam int SW = pidaw_pkg::SUM_W;
	localparam int FW = pidaw_pkg::FRAC_W;

	logic signed [AW:0]                   acc_wide;
	logic signed [AW-1:0]                 acc_sat;
	logic signed [pidaw_pkg::DIFF_W-1:0]  diff;
	logic signed [pidaw_pkg::PP_W-1:0]    prod_p;
	logic signed [pidaw_pkg::PI_W-1:0]    prod_i;
	logic signed [pidaw_pkg::PD_W-1:0]    prod_d;
	logic signed [SW-1:0]                 sum;
	logic signed [SW-1:0]                 lim_hi;
	logic signed [SW-1:0]                 lim_lo;

	always_comb begin
		// Tentative integral, saturated to the signed 32-bit range.
		acc_wide = $signed({accum[AW-1], accum}) + $signed({{(AW+1-DW){err[DW-1]}}, err});
		if (acc_wide[AW] != acc_wide[AW-1]) begin
			acc_sat = acc_wide[AW] ? pidaw_pkg::ACC_MIN : pidaw_pkg::ACC_MAX;
		end else begin
			acc_sat = acc_wide[AW-1:0];
		end

		diff   = $signed({err[DW-1], err}) - $signed({last_err[DW-1], last_err});
		prod_p = cfg.gain_p * err;
		prod_i = cfg.gain_i * acc_sat;
		prod_d = cfg.gain_d * diff;

		sum = $signed({{(SW-pidaw_pkg::PP_W){prod_p[pidaw_pkg::PP_W-1]}}, prod_p})
		    + $signed({{(SW-pidaw_pkg::PI_W){prod_i[pidaw_pkg::PI_W-1]}}, prod_i})
		    + $signed({{(SW-pidaw_pkg::PD_W){prod_d[pidaw_pkg::PD_W-1]}}, prod_d});

		lim_hi = $signed({{(SW-DW-FW){cfg.out_ceiling[DW-1]}}, cfg.out_ceiling, {FW{1'b0}}});
		lim_lo = $signed({{(SW-DW-FW){cfg.out_floor[DW-1]}}, cfg.out_floor, {FW{1'b0}}});

		// The high limit wins when the floor sits above the ceiling.
		if (sum > lim_hi) begin
			step.drive      = cfg.out_ceiling;
			step.clamp      = pidaw_pkg::CLAMP_HIGH;
			step.accum_next = accum;
		end else if (sum < lim_lo) begin
			step.drive      = cfg.out_floor;
			step.clamp      = pidaw_pkg::CLAMP_LOW;
			step.accum_next = accum;
		end else begin
			// Within limits the value fits, so the shift is a plain slice.
			step.drive      = sum[FW+DW-1:FW];
			step.clamp      = pidaw_pkg::CLAMP_NONE;
			step.accum_next = acc_sat;
		end
	end

endmodule

>>> rtl/pid_step_with_antiwindup.sv
`timescale 1ns / 1ps
`include "pid_step_with_antiwindup_defines.svh"
// PID step with output clamp and anti-windup. Each error beat is registered,
// then the saturating integral, the derivative, the three gain products, the
// limit compare and the Q8.8 rescale are all combinational into the result
// register, which loads the result once the result side can take it, and one
// beat is taken every cycle while the result side keeps taking results. That
// combinational path is also the integral feedback loop: the integral update
// of one beat is visible to the next. When the output hits a limit, the
// integral keeps its previous value and clamp_state reports which limit was
// hit. Write the gain and limit registers only while no beat is in flight.
module pid_step_with_antiwindup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                err_valid,
	output logic                                err_ready,
	input  logic signed [pidaw_pkg::DATA_W-1:0] err_sample,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [pidaw_pkg::DATA_W-1:0] drive,
	output logic [pidaw_pkg::CLAMP_W-1:0]       clamp_state,
	input  logic                                cfg_we,
	input  logic [pidaw_pkg::IDX_W-1:0]         cfg_index,
	input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata
);

	pidaw_pkg::cfg_t  cfg;
	pidaw_pkg::step_t step;

	logic                                valid_s1;
	logic signed [pidaw_pkg::DATA_W-1:0] err_s1;
	logic                                res_valid_q;
	logic signed [pidaw_pkg::DATA_W-1:0] drive_q;
	pidaw_pkg::clamp_t                   clamp_q;
	logic signed [pidaw_pkg::ACC_W-1:0]  accum_q;
	logic signed [pidaw_pkg::DATA_W-1:0] last_err_q;
	logic                                adv;
	logic                                fire_s1;

	pidaw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidaw_calc u_calc (
		.cfg      (cfg),
		.err      (err_s1),
		.accum    (accum_q),
		.last_err (last_err_q),
		.step     (step)
	);

	assign adv       = !res_valid_q || res_ready;
	assign fire_s1   = valid_s1 && adv;
	assign err_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (err_ready) begin
			valid_s1 <= err_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (err_valid && err_ready) begin
			err_s1 <= err_sample;
		end
	end

	// The loop state moves together with the result, so the next beat in
	// stage one always sees the state this beat leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			accum_q     <= '0;
			last_err_q  <= '0;
		end else if (fire_s1) begin
			res_valid_q <= 1'b1;
			accum_q     <= step.accum_next;
			last_err_q  <= err_s1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			drive_q <= step.drive;
			clamp_q <= step.clamp;
		end
	end

	assign res_valid   = res_valid_q;
	assign drive       = drive_q;
	assign clamp_state = clamp_q;

	`PIDAW_ASSERT_NEXT(a_hold_integral, fire_s1 && (step.clamp != pidaw_pkg::CLAMP_NONE), $stable(accum_q), "integral changed on a clamped step")
	`PIDAW_ASSERT_NEXT(a_last_err, fire_s1, last_err_q == $past(err_s1), "previous error not updated")
	`PIDAW_ASSERT_SAME(a_in_limits, res_valid_q && (clamp_q == pidaw_pkg::CLAMP_NONE), (drive_q >= cfg.out_floor) && (drive_q <= cfg.out_ceiling), "unclamped drive outside limits")

endmodule
